// ===== hdl/lbe_pkg.sv =====
package lbe_pkg;

   // Width of the free-running millisecond time stamp.
   localparam int unsigned TIME_WIDTH = 32;

   // Effect codes, as carried on the request and reported on the response.
   typedef enum logic [3:0] {
      EFFECT_OFF           = 4'd0,
      EFFECT_RED           = 4'd1,
      EFFECT_GREEN         = 4'd2,
      EFFECT_BLUE          = 4'd3,
      EFFECT_BLINK_RED     = 4'd4,
      EFFECT_BLINK_GREEN   = 4'd5,
      EFFECT_BLINK_BLUE    = 4'd6,
      EFFECT_BREATHE_RED   = 4'd7,
      EFFECT_BREATHE_GREEN = 4'd8,
      EFFECT_BREATHE_BLUE  = 4'd9
   } effect_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_BLINK_INTERVAL_MS = 3'd0;
   localparam logic [2:0] CSR_BLINK_COUNT       = 3'd1;
   localparam logic [2:0] CSR_BREATH_STEP_MS    = 3'd2;
   localparam logic [2:0] CSR_BREATH_STEP_SIZE  = 3'd3;
   localparam logic [2:0] CSR_BREATH_COUNT      = 3'd4;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   // Reset values of the configuration registers.
   localparam logic [15:0] BLINK_INTERVAL_RESET = 16'd200;
   localparam logic [7:0]  BLINK_COUNT_RESET    = 8'd5;
   localparam logic [15:0] BREATH_STEP_RESET    = 16'd30;
   localparam logic [7:0]  BREATH_SIZE_RESET    = 8'd20;
   localparam logic [7:0]  BREATH_COUNT_RESET   = 8'd3;

   localparam logic [7:0]  FULL_BRIGHTNESS = 8'd255;

   localparam logic [23:0] COLOUR_BLACK = 24'h000000;
   localparam logic [23:0] COLOUR_RED   = 24'hFF0000;
   localparam logic [23:0] COLOUR_GREEN = 24'h00FF00;
   localparam logic [23:0] COLOUR_BLUE  = 24'h0000FF;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] now_ms;
      logic [3:0]            requested_effect;
   } req_type;

   typedef struct packed {
      logic        strip_update;
      logic [23:0] pixel_colour;
      logic [7:0]  pixel_brightness;
      logic [3:0]  current_effect;
   } rsp_type;

   typedef struct packed {
      logic [15:0] blink_interval_ms;
      logic [7:0]  blink_count;
      logic [15:0] breath_step_ms;
      logic [7:0]  breath_step_size;
      logic [7:0]  breath_count;
   } cfg_type;

   typedef struct packed {
      effect_type            active_effect;
      logic [TIME_WIDTH-1:0] last_step_time;
      logic                  blink_lit;
      logic [7:0]            blinks_left;
      logic [7:0]            breath_level;
      logic                  breath_rising;
      logic [7:0]            breaths_left;
      logic [7:0]            applied_brightness;
   } fx_state_type;

   function automatic logic [23:0] effect_colour(input effect_type e);
      logic [23:0] c;
      case (e)
         EFFECT_RED, EFFECT_BLINK_RED, EFFECT_BREATHE_RED:       c = COLOUR_RED;
         EFFECT_GREEN, EFFECT_BLINK_GREEN, EFFECT_BREATHE_GREEN: c = COLOUR_GREEN;
         EFFECT_BLUE, EFFECT_BLINK_BLUE, EFFECT_BREATHE_BLUE:    c = COLOUR_BLUE;
         default:                                                c = COLOUR_BLACK;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/lbe_csr.sv =====
module lbe_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lbe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lbe_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output lbe_pkg::cfg_type                     cfg
);

   lbe_pkg::cfg_type cfg_ff;
   lbe_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lbe_pkg::CSR_BLINK_INTERVAL_MS: cfg_in.blink_interval_ms = csr_wdata;
            lbe_pkg::CSR_BLINK_COUNT:       cfg_in.blink_count       = csr_wdata[7:0];
            lbe_pkg::CSR_BREATH_STEP_MS:    cfg_in.breath_step_ms    = csr_wdata;
            lbe_pkg::CSR_BREATH_STEP_SIZE:  cfg_in.breath_step_size  = csr_wdata[7:0];
            lbe_pkg::CSR_BREATH_COUNT:      cfg_in.breath_count      = csr_wdata[7:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_interval_ms <= lbe_pkg::BLINK_INTERVAL_RESET;
         cfg_ff.blink_count       <= lbe_pkg::BLINK_COUNT_RESET;
         cfg_ff.breath_step_ms    <= lbe_pkg::BREATH_STEP_RESET;
         cfg_ff.breath_step_size  <= lbe_pkg::BREATH_SIZE_RESET;
         cfg_ff.breath_count      <= lbe_pkg::BREATH_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/lbe_step.sv =====
module lbe_step (
   input  lbe_pkg::cfg_type      cfg,
   input  lbe_pkg::fx_state_type state_cur,
   input  lbe_pkg::req_type      req,
   output lbe_pkg::fx_state_type state_nxt,
   output lbe_pkg::rsp_type      rsp
);

   lbe_pkg::effect_type                 req_effect;
   lbe_pkg::fx_state_type               st;
   logic                                upd;
   logic [23:0]                         colour;
   logic [lbe_pkg::TIME_WIDTH-1:0]      elapsed;
   logic signed [9:0]                   level_sum;
   logic                                done;

   always_comb begin
      // Codes above the last effect are treated as off.
      if (req.requested_effect > lbe_pkg::EFFECT_BREATHE_BLUE) begin
         req_effect = lbe_pkg::EFFECT_OFF;
      end else begin
         req_effect = lbe_pkg::effect_type'(req.requested_effect);
      end

      st        = state_cur;
      upd       = 1'b0;
      colour    = lbe_pkg::COLOUR_BLACK;
      level_sum = '0;
      done      = 1'b0;

      // A new request restarts the timer and reloads the effect's counters.
      if (req_effect != state_cur.active_effect) begin
         st.active_effect  = req_effect;
         st.last_step_time = req.now_ms;
         st.blink_lit      = 1'b0;
         if (req_effect <= lbe_pkg::EFFECT_BLUE) begin
            upd    = 1'b1;
            colour = lbe_pkg::effect_colour(req_effect);
         end else if (req_effect <= lbe_pkg::EFFECT_BLINK_BLUE) begin
            st.blinks_left = cfg.blink_count;
         end else begin
            st.breaths_left  = cfg.breath_count;
            st.breath_level  = '0;
            st.breath_rising = 1'b1;
         end
      end

      elapsed = req.now_ms - st.last_step_time;

      if (st.active_effect inside {[lbe_pkg::EFFECT_BLINK_RED:lbe_pkg::EFFECT_BLINK_BLUE]})
      begin
         if (elapsed >= lbe_pkg::TIME_WIDTH'(cfg.blink_interval_ms)) begin
            st.last_step_time = req.now_ms;
            st.blink_lit      = !st.blink_lit;
            upd               = 1'b1;
            if (st.blink_lit) begin
               colour = lbe_pkg::effect_colour(st.active_effect);
            end else begin
               colour = lbe_pkg::COLOUR_BLACK;
               if (st.blinks_left != 8'd0) begin
                  st.blinks_left = st.blinks_left - 8'd1;
               end
            end
            if (st.blinks_left == 8'd0) begin
               st.active_effect = lbe_pkg::EFFECT_OFF;
               colour           = lbe_pkg::COLOUR_BLACK;
            end
         end
      end else if (st.active_effect >= lbe_pkg::EFFECT_BREATHE_RED) begin
         if (elapsed >= lbe_pkg::TIME_WIDTH'(cfg.breath_step_ms)) begin
            st.last_step_time = req.now_ms;
            if (st.breath_rising) begin
               level_sum = $signed({2'b00, st.breath_level}) +
                           $signed({2'b00, cfg.breath_step_size});
            end else begin
               level_sum = $signed({2'b00, st.breath_level}) -
                           $signed({2'b00, cfg.breath_step_size});
            end
            if (level_sum >= 10'sd255) begin
               st.breath_level  = 8'd255;
               st.breath_rising = 1'b0;
            end else if (level_sum <= 10'sd0) begin
               st.breath_level  = 8'd0;
               st.breath_rising = 1'b1;
               if (st.breaths_left <= 8'd1) begin
                  st.breaths_left = 8'd0;
                  done            = 1'b1;
               end else begin
                  st.breaths_left = st.breaths_left - 8'd1;
               end
            end else begin
               st.breath_level = level_sum[7:0];
            end
            upd = 1'b1;
            if (done) begin
               st.active_effect = lbe_pkg::EFFECT_OFF;
               colour           = lbe_pkg::COLOUR_BLACK;
            end else begin
               st.applied_brightness = st.breath_level;
               colour                = lbe_pkg::effect_colour(st.active_effect);
            end
         end
      end

      state_nxt            = st;
      rsp.strip_update     = upd;
      rsp.pixel_colour     = upd ? colour : lbe_pkg::COLOUR_BLACK;
      rsp.pixel_brightness = st.applied_brightness;
      rsp.current_effect   = st.active_effect;
   end

endmodule

// ===== hdl/led_blink_breathe_effect_fsm_core.sv =====
// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_ready    req_data   (lbe_pkg::req_type)
// rsp      out        rsp_valid / rsp_ready    rsp_data   (lbe_pkg::rsp_type)
// csr      in         csr_we, no wait          csr_index, csr_wdata
//
// Every request gives exactly one response, passing first through the input register
// and then into the response register; one request per clock is sustained while the
// response side is not stalled. A single step stage lies between the input register and
// the response register: the effect state is updated at the same edge as the response.
// Reset is synchronous and active high; it restores the register defaults, selects
// the off effect and full brightness, and empties both pipeline registers.
// A stalled response holds in its register while one more request may wait in
// the input register; further requests are held off by req_ready.
module led_blink_breathe_effect_fsm_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lbe_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lbe_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [lbe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lbe_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   lbe_pkg::cfg_type      cfg;

   // Input register: holds the accepted request until the step stage consumes it.
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   lbe_pkg::req_type      s1_data_ff;

   // Effect state that persists from one request to the next.
   lbe_pkg::fx_state_type fx_ff;
   lbe_pkg::fx_state_type fx_in;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   lbe_pkg::rsp_type      rsp_data_ff;
   lbe_pkg::rsp_type      step_rsp;

   logic                  advance;
   logic                  req_take;

   lbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lbe_step u_step (
      .cfg       (cfg),
      .state_cur (fx_ff),
      .req       (s1_data_ff),
      .state_nxt (fx_in),
      .rsp       (step_rsp)
   );

   // The step stage fires when it holds a request and the response register is
   // free or is being emptied in this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fx_ff.active_effect      <= lbe_pkg::EFFECT_OFF;
         fx_ff.last_step_time     <= '0;
         fx_ff.blink_lit          <= 1'b0;
         fx_ff.blinks_left        <= '0;
         fx_ff.breath_level       <= '0;
         fx_ff.breath_rising      <= 1'b1;
         fx_ff.breaths_left       <= '0;
         fx_ff.applied_brightness <= lbe_pkg::FULL_BRIGHTNESS;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            fx_ff <= fx_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/lbe_checker.sv =====
module lbe_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lbe_pkg::rsp_type rsp_data
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Nothing is presented in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A colour is only reported with a strip rewrite.
   a_colour_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.strip_update |-> rsp_data.pixel_colour == 24'h000000)
      else $error("colour reported without a strip rewrite");

   // The reported effect is always a known code.
   a_effect_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.current_effect <= lbe_pkg::EFFECT_BREATHE_BLUE)
      else $error("unknown effect reported");

   // A lit colour never comes with the effect having fallen back to off.
   a_lit_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.strip_update && (rsp_data.pixel_colour != 24'h000000)
      |-> rsp_data.current_effect != lbe_pkg::EFFECT_OFF)
      else $error("colour written while effect is off");

endmodule

bind led_blink_breathe_effect_fsm_core lbe_checker u_lbe_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_led_blink_breathe_effect_fsm_core.sv =====
module tb_led_blink_breathe_effect_fsm_core;
   timeunit 1ns;
   timeprecision 1ps;

   // Request codes above the last effect. The block treats them as off.
   localparam logic [3:0] UNKNOWN_LOW  = 4'hA;
   localparam logic [3:0] UNKNOWN_HIGH = 4'hF;

   // Hard stop for the run, in clock cycles.
   localparam int CYCLE_LIMIT = 500000;

   localparam int RANDOM_PHASES   = 8;
   localparam int POLLS_PER_PHASE = 75;

   // One queued request, plus a flag that makes the sender hold it back until
   // every outstanding response has come home.
   typedef struct {
      lbe_pkg::req_type poll;
      bit               drain;
   } poll_slot_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   lbe_pkg::req_type                    req_data = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   lbe_pkg::rsp_type                    rsp_data;
   logic                                csr_we = 1'b0;
   logic [lbe_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [lbe_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   poll_slot_type    poll_queue[$];
   lbe_pkg::rsp_type expected_rsp[$];

   // Shadow copy of the register file.
   logic [15:0] cfg_blink_ms    = lbe_pkg::BLINK_INTERVAL_RESET;
   logic [7:0]  cfg_blink_n     = lbe_pkg::BLINK_COUNT_RESET;
   logic [15:0] cfg_breath_ms   = lbe_pkg::BREATH_STEP_RESET;
   logic [7:0]  cfg_breath_size = lbe_pkg::BREATH_SIZE_RESET;
   logic [7:0]  cfg_breath_n    = lbe_pkg::BREATH_COUNT_RESET;

   // Shadow copy of the effect state, at its reset values. The level is kept
   // as a signed integer because a step may overshoot before it is clamped.
   lbe_pkg::effect_type fx_effect  = lbe_pkg::EFFECT_OFF;
   logic [31:0]         fx_mark    = '0;
   logic                fx_lit     = 1'b0;
   logic [7:0]          fx_blinks  = '0;
   int                  fx_level   = 0;
   logic                fx_rising  = 1'b1;
   logic [7:0]          fx_breaths = '0;
   logic [7:0]          fx_bright  = lbe_pkg::FULL_BRIGHTNESS;

   logic [31:0] poll_time = '0;
   logic        req_fire = 1'b0;
   bit          sender_calm = 1'b0;
   bit          receiver_calm = 1'b0;
   int          send_wait = 0;
   int          hold_off = 0;

   int cycle_count = 0;
   int fail_count = 0;
   int sent_count = 0;
   int rsp_seen = 0;
   int rewrites = 0;
   int blink_done = 0;
   int breathe_done = 0;
   int setting_count = 0;

   always #2 clock = ~clock;

   led_blink_breathe_effect_fsm_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic logic [23:0] colour_of(input lbe_pkg::effect_type e);
      case (e)
         lbe_pkg::EFFECT_RED, lbe_pkg::EFFECT_BLINK_RED, lbe_pkg::EFFECT_BREATHE_RED:
            return lbe_pkg::COLOUR_RED;
         lbe_pkg::EFFECT_GREEN, lbe_pkg::EFFECT_BLINK_GREEN, lbe_pkg::EFFECT_BREATHE_GREEN:
            return lbe_pkg::COLOUR_GREEN;
         lbe_pkg::EFFECT_BLUE, lbe_pkg::EFFECT_BLINK_BLUE, lbe_pkg::EFFECT_BREATHE_BLUE:
            return lbe_pkg::COLOUR_BLUE;
         default:
            return lbe_pkg::COLOUR_BLACK;
      endcase
   endfunction

   // Advances the shadow effect state by one poll and returns the response
   // that the block owes for it.
   function automatic void predict_poll(input lbe_pkg::req_type rq,
                                        output lbe_pkg::rsp_type rs);
      lbe_pkg::effect_type want;
      logic                upd;
      logic [23:0]         colour;
      logic [31:0]         span_ms;
      bit                  finished;

      want = (rq.requested_effect > lbe_pkg::EFFECT_BREATHE_BLUE)
             ? lbe_pkg::EFFECT_OFF : lbe_pkg::effect_type'(rq.requested_effect);
      upd = 1'b0;
      colour = lbe_pkg::COLOUR_BLACK;
      finished = 1'b0;

      // A new request restarts the timer and reloads the counters of the
      // chosen effect. Static effects paint the strip right away.
      if (want != fx_effect) begin
         fx_effect = want;
         fx_mark = rq.now_ms;
         fx_lit = 1'b0;
         if (want <= lbe_pkg::EFFECT_BLUE) begin
            upd = 1'b1;
            colour = colour_of(want);
         end else if (want <= lbe_pkg::EFFECT_BLINK_BLUE) begin
            fx_blinks = cfg_blink_n;
         end else begin
            fx_breaths = cfg_breath_n;
            fx_level = 0;
            fx_rising = 1'b1;
         end
      end

      // Elapsed time wraps with the 32-bit clock.
      span_ms = rq.now_ms - fx_mark;

      if (fx_effect >= lbe_pkg::EFFECT_BLINK_RED && fx_effect <= lbe_pkg::EFFECT_BLINK_BLUE)
      begin
         if (span_ms >= {16'd0, cfg_blink_ms}) begin
            fx_mark = rq.now_ms;
            fx_lit = !fx_lit;
            upd = 1'b1;
            if (fx_lit) begin
               colour = colour_of(fx_effect);
            end else begin
               colour = lbe_pkg::COLOUR_BLACK;
               if (fx_blinks != 0) fx_blinks = fx_blinks - 8'd1;
            end
            if (fx_blinks == 0) begin
               fx_effect = lbe_pkg::EFFECT_OFF;
               colour = lbe_pkg::COLOUR_BLACK;
               blink_done++;
            end
         end
      end else if (fx_effect >= lbe_pkg::EFFECT_BREATHE_RED) begin
         if (span_ms >= {16'd0, cfg_breath_ms}) begin
            fx_mark = rq.now_ms;
            if (fx_rising) fx_level = fx_level + int'(cfg_breath_size);
            else fx_level = fx_level - int'(cfg_breath_size);
            if (fx_level >= int'(lbe_pkg::FULL_BRIGHTNESS)) begin
               fx_level = int'(lbe_pkg::FULL_BRIGHTNESS);
               fx_rising = 1'b0;
            end else if (fx_level <= 0) begin
               // Back at the bottom: one full breath is complete.
               fx_level = 0;
               fx_rising = 1'b1;
               if (fx_breaths <= 8'd1) begin
                  fx_breaths = '0;
                  finished = 1'b1;
               end else begin
                  fx_breaths = fx_breaths - 8'd1;
               end
            end
            upd = 1'b1;
            if (finished) begin
               fx_effect = lbe_pkg::EFFECT_OFF;
               colour = lbe_pkg::COLOUR_BLACK;
               breathe_done++;
            end else begin
               fx_bright = fx_level[7:0];
               colour = colour_of(fx_effect);
            end
         end
      end

      if (upd) rewrites++;
      rs.strip_update = upd;
      rs.pixel_colour = upd ? colour : lbe_pkg::COLOUR_BLACK;
      rs.pixel_brightness = fx_bright;
      rs.current_effect = fx_effect;
   endfunction

   // Idle length for either side: usually none, often short, now and
   // then a long one. A calm phase never idles.
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Sender. Requests are presented at the falling edge and stay put until
   // the rising edge that accepts them. The valid is assigned once per edge
   // so a back-to-back request never sees a low pulse.
   always @(negedge clock) begin : feeder
      logic          next_valid;
      poll_slot_type head;

      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_fire) begin
         next_valid = 1'b0;
         if (send_wait > 0) begin
            send_wait--;
         end else if (poll_queue.size() > 0 &&
                      (!poll_queue[0].drain || expected_rsp.size() == 0)) begin
            head = poll_queue.pop_front();
            req_data <= head.poll;
            next_valid = 1'b1;
            sent_count++;
            send_wait = pick_gap(sender_calm);
         end
      end
      req_valid <= next_valid;
   end

   // Receiver. Ready drops for random stretches so that responses back up
   // into the block and push back on the request side.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         hold_off = pick_gap(receiver_calm);
      end
   end

   // Monitor. Responses are checked before the request of the same edge is
   // predicted, so a response can never be matched to its own request.
   always @(posedge clock) begin : monitor
      lbe_pkg::rsp_type want;
      lbe_pkg::rsp_type got;

      cycle_count++;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               note_failure("response with no request outstanding");
            end else begin
               want = expected_rsp.pop_front();
               if (got.strip_update !== want.strip_update ||
                   got.pixel_colour !== want.pixel_colour ||
                   got.pixel_brightness !== want.pixel_brightness ||
                   got.current_effect !== want.current_effect)
                  note_failure({
                     $sformatf("response %0d: expected upd=%b colour=%h bright=%h effect=%h",
                               rsp_seen, want.strip_update, want.pixel_colour,
                               want.pixel_brightness, want.current_effect),
                     $sformatf(", got upd=%b colour=%h bright=%h effect=%h",
                               got.strip_update, got.pixel_colour,
                               got.pixel_brightness, got.current_effect)});
            end
         end
         if (req_valid && req_ready) begin
            predict_poll(req_data, want);
            expected_rsp.push_back(want);
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles", cycle_count);
         $display("led_blink_breathe_effect_fsm_core verification failed");
         $finish;
      end
   end

   // Returns once nothing is queued, nothing is on the wire and every
   // response has been checked; then lets the two pipeline stages settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (poll_queue.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle. The shadow copy
   // is updated with the write since no request is in flight.
   task automatic write_reg(input logic [lbe_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         lbe_pkg::CSR_BLINK_INTERVAL_MS: cfg_blink_ms = value;
         lbe_pkg::CSR_BLINK_COUNT:       cfg_blink_n = value[7:0];
         lbe_pkg::CSR_BREATH_STEP_MS:    cfg_breath_ms = value;
         lbe_pkg::CSR_BREATH_STEP_SIZE:  cfg_breath_size = value[7:0];
         lbe_pkg::CSR_BREATH_COUNT:      cfg_breath_n = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(input logic [15:0] blink_ms, input logic [7:0] blink_n,
                                 input logic [15:0] step_ms, input logic [7:0] step_size,
                                 input logic [7:0] breath_n);
      write_reg(lbe_pkg::CSR_BLINK_INTERVAL_MS, blink_ms);
      write_reg(lbe_pkg::CSR_BLINK_COUNT, {8'd0, blink_n});
      write_reg(lbe_pkg::CSR_BREATH_STEP_MS, step_ms);
      write_reg(lbe_pkg::CSR_BREATH_STEP_SIZE, {8'd0, step_size});
      write_reg(lbe_pkg::CSR_BREATH_COUNT, {8'd0, breath_n});
      setting_count++;
      // Queue pushes happen away from the falling edge the sender acts on.
      @(posedge clock);
   endtask

   task automatic push_poll(input logic [31:0] t, input logic [3:0] code, input bit drain);
      poll_slot_type slot;
      slot.poll.now_ms = t;
      slot.poll.requested_effect = code;
      slot.drain = drain;
      poll_queue.push_back(slot);
   endtask

   // Moves the running clock forward by an amount related to the step time
   // of the effect, so that steps both fire and fail to fire. Rarely the time
   // jumps far ahead or to a random value.
   task automatic advance_time(input int unsigned span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) ;
      else if (r < 50) poll_time = poll_time + $urandom_range(0, span);
      else if (r < 80) poll_time = poll_time + span + $urandom_range(0, 3);
      else if (r < 95) poll_time = poll_time + $urandom_range(0, 2 * span + 1);
      else if (r < 98) poll_time = poll_time + $urandom;
      else poll_time = $urandom;
   endtask

   // Runs of polls that keep asking for one effect so it can blink or breathe
   // through to the end, with an occasional stray request in between.
   task automatic queue_random_polls(input int count);
      int          made;
      int          run_len;
      int          r;
      logic [3:0]  code;
      logic [3:0]  ask;
      int unsigned span;

      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 35)
            code = 4'($urandom_range(lbe_pkg::EFFECT_BLINK_RED, lbe_pkg::EFFECT_BLINK_BLUE));
         else if (r < 70)
            code = 4'($urandom_range(lbe_pkg::EFFECT_BREATHE_RED,
                                     lbe_pkg::EFFECT_BREATHE_BLUE));
         else if (r < 90)
            code = 4'($urandom_range(lbe_pkg::EFFECT_OFF, lbe_pkg::EFFECT_BLUE));
         else code = 4'($urandom_range(UNKNOWN_LOW, UNKNOWN_HIGH));
         if (code >= lbe_pkg::EFFECT_BLINK_RED && code <= lbe_pkg::EFFECT_BLINK_BLUE)
            span = 32'(cfg_blink_ms);
         else if (code >= lbe_pkg::EFFECT_BREATHE_RED && code <= lbe_pkg::EFFECT_BREATHE_BLUE)
            span = 32'(cfg_breath_ms);
         else span = $urandom_range(0, 50);
         run_len = $urandom_range(4, 40);
         for (int k = 0; k < run_len && made < count; k++) begin
            ask = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : code;
            advance_time(span);
            push_poll(poll_time, ask, $urandom_range(0, 49) == 0);
            made++;
         end
      end
   endtask

   initial begin
      int r;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed polls at the reset settings: static colours, unknown codes,
      // a blink that waits one tick short of its interval, a breathe that is
      // cut off by an off request and keeps its last brightness.
      sender_calm = 1'b1;
      receiver_calm = 1'b0;
      push_poll(32'd0, lbe_pkg::EFFECT_OFF, 1'b0);
      push_poll(32'd1, lbe_pkg::EFFECT_RED, 1'b0);
      push_poll(32'd2, lbe_pkg::EFFECT_GREEN, 1'b0);
      push_poll(32'd3, lbe_pkg::EFFECT_BLUE, 1'b0);
      push_poll(32'd4, UNKNOWN_LOW + 4'd2, 1'b0);
      push_poll(32'd5, UNKNOWN_HIGH, 1'b0);
      push_poll(32'd10, lbe_pkg::EFFECT_BLINK_RED, 1'b0);
      push_poll(32'd209, lbe_pkg::EFFECT_BLINK_RED, 1'b0);
      push_poll(32'd210, lbe_pkg::EFFECT_BLINK_RED, 1'b0);
      push_poll(32'd410, lbe_pkg::EFFECT_BLINK_RED, 1'b0);
      push_poll(32'd411, lbe_pkg::EFFECT_BLINK_GREEN, 1'b0);
      // The sender holds this one back until every response is in.
      push_poll(32'd700, lbe_pkg::EFFECT_BREATHE_BLUE, 1'b1);
      push_poll(32'd730, lbe_pkg::EFFECT_BREATHE_BLUE, 1'b0);
      push_poll(32'd760, lbe_pkg::EFFECT_BREATHE_BLUE, 1'b0);
      push_poll(32'd5000, lbe_pkg::EFFECT_BREATHE_BLUE, 1'b0);
      push_poll(32'd5001, lbe_pkg::EFFECT_OFF, 1'b0);
      wait_idle();

      // All zero: every effect steps on the poll that starts it, zero counts
      // end at the first step, and a zero step size finishes a breath at once.
      apply_settings(16'd0, 8'd0, 16'd0, 8'd0, 8'd0);
      push_poll(32'd6000, lbe_pkg::EFFECT_BLINK_BLUE, 1'b0);
      push_poll(32'd6000, lbe_pkg::EFFECT_BLINK_BLUE, 1'b0);
      push_poll(32'd6001, lbe_pkg::EFFECT_BREATHE_GREEN, 1'b0);
      push_poll(32'hFFFF_FFFF, lbe_pkg::EFFECT_RED, 1'b0);
      wait_idle();

      // Longest intervals, single cycles and the largest step: elapsed time
      // is checked one short of the interval, exactly at it and across wrap.
      apply_settings(16'hFFFF, 8'd1, 16'hFFFF, 8'hFF, 8'd1);
      push_poll(32'hFFFF_0000, lbe_pkg::EFFECT_BLINK_RED, 1'b0);
      push_poll(32'hFFFF_FFFE, lbe_pkg::EFFECT_BLINK_RED, 1'b0);
      push_poll(32'hFFFF_FFFF, lbe_pkg::EFFECT_BLINK_RED, 1'b0);
      push_poll(32'h0000_FFFF, lbe_pkg::EFFECT_BLINK_RED, 1'b0);
      push_poll(32'h0001_0000, lbe_pkg::EFFECT_BREATHE_RED, 1'b0);
      push_poll(32'h0002_0000, lbe_pkg::EFFECT_BREATHE_RED, 1'b0);
      push_poll(32'h0003_0000, lbe_pkg::EFFECT_BREATHE_RED, 1'b0);
      wait_idle();

      // Random phases, each with its own register setting and idle pattern.
      // The first uses every register at its maximum, the second goes back
      // to the reset values, the rest mix extremes with short step times.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         receiver_calm = ($urandom_range(0, 3) == 0);
         if (p == 0) begin
            apply_settings(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
         end else if (p == 1) begin
            apply_settings(lbe_pkg::BLINK_INTERVAL_RESET, lbe_pkg::BLINK_COUNT_RESET,
                           lbe_pkg::BREATH_STEP_RESET, lbe_pkg::BREATH_SIZE_RESET,
                           lbe_pkg::BREATH_COUNT_RESET);
         end else begin
            logic [15:0] bi, bs;
            logic [7:0]  bn, sz, cn;
            r = $urandom_range(0, 9);
            bi = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 20));
            r = $urandom_range(0, 9);
            bn = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : 8'($urandom_range(1, 4));
            r = $urandom_range(0, 9);
            bs = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 20));
            r = $urandom_range(0, 9);
            sz = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'hFF
                                 : 8'($urandom_range(20, 128));
            r = $urandom_range(0, 9);
            cn = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : 8'($urandom_range(1, 3));
            apply_settings(bi, bn, bs, sz, cn);
         end
         // Some phases start just below the wrap point of the clock.
         if ($urandom_range(0, 2) == 0) poll_time = 32'hFFFF_FFFF - $urandom_range(0, 2000);
         queue_random_polls(POLLS_PER_PHASE);
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (expected_rsp.size() != 0)
         note_failure($sformatf("%0d responses never arrived", expected_rsp.size()));

      $display("Summary: %0d polls over %0d register settings, %0d responses checked.",
               sent_count, setting_count, rsp_seen);
      $display("Summary: %0d strip rewrites, %0d blinks and %0d breathes ran to the end.",
               rewrites, blink_done, breathe_done);
      if (fail_count == 0) begin
         $display("led_blink_breathe_effect_fsm_core verification clean");
      end else begin
         $display("%0d failures", fail_count);
         $display("led_blink_breathe_effect_fsm_core verification failed");
      end
      $finish;
   end

endmodule
